// ===== rtl/core/lkv_pkg.sv =====
// lkv_pkg: shared widths, action codes, controller states and command struct
// for the lru key-value cache; no dependencies
`default_nettype none

package lkv_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 31;
  localparam int ACT_W       = 2;
  localparam int CAP_W       = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_ERASE  = 2'd2
  } action_e;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_APPLY = 1'b1
  } state_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/lru_key_value_cache.sv =====
// lru_key_value_cache: top level of the fully associative lru key-value cache
// depends on lkv_pkg, lkv_ctrl, lkv_datapath
`default_nettype none

// Fully associative key-value cache of Entries slots kept in recency order
// (slot 0 most recent). Each request is a lookup, an insert or an erase and
// gives exactly one result (hit, value_out). A request passes two steps: the
// accept cycle registers the key compare against all held slots; the commit
// step shifts the slot row and loads the result register once it is free.
// No new request is taken before the commit; the result register lets a
// new request in while the previous result waits. capacity_in_use is
// written through the cfg channel (always ready); the user must write it
// only while the cache is idle, the block does not enforce it. Values above
// Entries act as Entries. Lowering it does not drop entries at once: each
// later insert evicts one least recent entry. No clearing pass is needed
// after reset; the entry count starts at zero.
module lru_key_value_cache #(
  parameter int Entries = lkv_pkg::ENTRIES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lkv_pkg::CAP_W-1:0]     cfg_capacity_in_use_i,
  // request channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [lkv_pkg::ACT_W-1:0]     in_action_i,
  input  wire logic signed [lkv_pkg::KEY_W-1:0] in_key_i,
  input  wire logic [lkv_pkg::VAL_W-1:0]     in_new_value_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               out_hit_o,
  output logic [lkv_pkg::VAL_W-1:0]          out_value_out_o
);

  lkv_pkg::cmd_t cmd;

  // capacity register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  // sequencer: capture on accept, commit once the result register is free
  lkv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // slot row, compare, shift network and result registers
  lkv_datapath #(
    .Entries (Entries)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_capacity_in_use_i),
    .in_action_i (in_action_i),
    .in_key_i    ($unsigned(in_key_i)),
    .in_value_i  (in_new_value_i),
    .out_hit_o   (out_hit_o),
    .out_value_o (out_value_out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/lkv_ctrl.sv =====
// lkv_ctrl: request sequencer for the lru key-value cache
// depends on lkv_pkg (state_e, cmd_t)
`default_nettype none

module lkv_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic         out_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output lkv_pkg::cmd_t     cmd_o
);

  lkv_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lkv_pkg::S_IDLE: begin
        if (in_valid_i) state_d = lkv_pkg::S_APPLY;
      end
      lkv_pkg::S_APPLY: begin
        if (out_free) state_d = lkv_pkg::S_IDLE;
      end
      default: state_d = lkv_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      lkv_pkg::S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      lkv_pkg::S_APPLY: begin
        cmd_o.commit = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lkv_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lkv_datapath.sv =====
// lkv_datapath: recency-ordered key/value slots, parallel key match,
// shift network, entry count, capacity register and result registers
// depends on lkv_pkg (widths, action_e, cmd_t)
`default_nettype none

module lkv_datapath #(
  parameter int Entries = lkv_pkg::ENTRIES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lkv_pkg::cmd_t                 cmd_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [lkv_pkg::CAP_W-1:0]     cfg_data_i,
  input  wire logic [lkv_pkg::ACT_W-1:0]     in_action_i,
  input  wire logic [lkv_pkg::KEY_W-1:0]     in_key_i,
  input  wire logic [lkv_pkg::VAL_W-1:0]     in_value_i,
  output logic                               out_hit_o,
  output logic [lkv_pkg::VAL_W-1:0]          out_value_o
);

  localparam int CNT_W = $clog2(Entries + 1);
  localparam int CMP_W = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;

  logic [lkv_pkg::KEY_W-1:0] key_q [Entries];
  logic [lkv_pkg::KEY_W-1:0] key_d [Entries];
  logic [lkv_pkg::VAL_W-1:0] val_q [Entries];
  logic [lkv_pkg::VAL_W-1:0] val_d [Entries];
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [lkv_pkg::CAP_W-1:0] cap_q;

  logic [lkv_pkg::ACT_W-1:0] req_act_q;
  logic [lkv_pkg::KEY_W-1:0] req_key_q;
  logic [lkv_pkg::VAL_W-1:0] req_val_q;
  logic [Entries-1:0]        match_q, match_d;

  logic                      hit_q, hit_d;
  logic [lkv_pkg::VAL_W-1:0] value_q, value_d;

  logic [Entries-1:0]        le;
  logic [lkv_pkg::VAL_W-1:0] sel_val;
  logic                      any_hit;
  logic                      do_front, do_push, do_erase, is_insert;
  logic [CNT_W-1:0]          cap_eff, cnt_push, cnt_pre, cnt_ins;

  // compare against held entries only
  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      match_d[i] = (CNT_W'(i) < cnt_q) && (key_q[i] == in_key_i);
    end
  end

  // le[i]: matching entry sits at or above slot i
  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      le[i] = 1'b0;
      for (int j = 0; j <= i; j++) begin
        le[i] = le[i] | match_q[j];
      end
    end
  end

  always_comb begin
    sel_val = '0;
    for (int i = 0; i < Entries; i++) begin
      sel_val = sel_val | ({lkv_pkg::VAL_W{match_q[i]}} & val_q[i]);
    end
  end

  assign any_hit = |match_q;

  always_comb begin
    do_front  = 1'b0;
    do_push   = 1'b0;
    do_erase  = 1'b0;
    is_insert = 1'b0;
    unique case (req_act_q)
      lkv_pkg::ACT_LOOKUP: do_front = any_hit;
      lkv_pkg::ACT_INSERT: begin
        is_insert = 1'b1;
        do_front  = any_hit;
        do_push   = !any_hit;
      end
      lkv_pkg::ACT_ERASE:  do_erase = any_hit;
      default: ;
    endcase
  end

  // capacity saturates at the slot count
  assign cap_eff = (CMP_W'(cap_q) > CMP_W'(Entries)) ? CNT_W'(Entries) : CNT_W'(cap_q);
  assign cnt_push = (cnt_q >= CNT_W'(Entries)) ? CNT_W'(Entries) : cnt_q + 1'b1;
  assign cnt_pre  = any_hit ? cnt_q : cnt_push;
  assign cnt_ins  = (CMP_W'(cnt_pre) > CMP_W'(cap_eff)) ? cnt_pre - 1'b1 : cnt_pre;

  always_comb begin
    cnt_d = cnt_q;
    if (is_insert) cnt_d = cnt_ins;
    else if (do_erase) cnt_d = cnt_q - 1'b1;
  end

  // shift network
  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      key_d[i] = key_q[i];
      val_d[i] = val_q[i];
    end
    if (do_front) begin
      key_d[0] = req_key_q;
      val_d[0] = sel_val;
      // slots from 1 up to the matching one slide down by one
      for (int i = 1; i < Entries; i++) begin
        if (!le[i-1]) begin
          key_d[i] = key_q[i-1];
          val_d[i] = val_q[i-1];
        end
      end
    end else if (do_push) begin
      key_d[0] = req_key_q;
      val_d[0] = req_val_q;
      for (int i = 1; i < Entries; i++) begin
        key_d[i] = key_q[i-1];
        val_d[i] = val_q[i-1];
      end
    end else if (do_erase) begin
      for (int i = 0; i < Entries - 1; i++) begin
        if (le[i]) begin
          key_d[i] = key_q[i+1];
          val_d[i] = val_q[i+1];
        end
      end
    end
  end

  always_comb begin
    hit_d   = any_hit && ((req_act_q == lkv_pkg::ACT_LOOKUP) ||
                          (req_act_q == lkv_pkg::ACT_ERASE));
    value_d = ((req_act_q == lkv_pkg::ACT_LOOKUP) && any_hit) ? sel_val : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cap_q <= lkv_pkg::CAP_RESET;
    end else begin
      if (cmd_i.commit) cnt_q <= cnt_d;
      if (cfg_we_i) cap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_act_q <= in_action_i;
      req_key_q <= in_key_i;
      req_val_q <= in_value_i;
      match_q   <= match_d;
    end
    if (cmd_i.commit) begin
      for (int i = 0; i < Entries; i++) begin
        key_q[i] <= key_d[i];
        val_q[i] <= val_d[i];
      end
      hit_q   <= hit_d;
      value_q <= value_d;
    end
  end

  assign out_hit_o   = hit_q;
  assign out_value_o = value_q;

endmodule

`default_nettype wire

// ===== rtl/core/lkv_checker.sv =====
// lkv_checker: port-level assertions for lru_key_value_cache, bound to the top
// depends on lkv_pkg (widths)
`default_nettype none

module lkv_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic                          out_hit_o,
  input wire logic [lkv_pkg::VAL_W-1:0]     out_value_out_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_hit_o) &&
    $stable(out_value_out_o))
    else $error("stalled result changed");

  // a nonzero value only comes with a hit
  a_value_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_value_out_o != '0) |-> out_hit_o)
    else $error("value without hit");

  // a request occupies the cycle after its accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted back to back");

  // the result of an accepted request is on offer after its commit step loads the result register
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("missing result");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: self-checking bench for the lru key-value cache, with a recency
// order predictor, a directed request table and randomized request phases
// depends on lkv_pkg and lru_key_value_cache
`timescale 1ns / 100ps

module testbench;

  localparam int ENTRIES     = lkv_pkg::ENTRIES_DEF;
  // unused action code, the cache treats it as a no-op
  localparam logic [lkv_pkg::ACT_W-1:0] ACT_NOP = 2'd3;
  localparam int NUM_PHASES  = 11;
  localparam int PHASE_ITEMS = 180;
  localparam int POOL_SIZE   = 22;
  // receiver hold-off long enough to back up the request side
  localparam int HOLD_CYCLES = 200;
  // idle cycles before a capacity write and after the last result
  localparam int CFG_GUARD   = 4;
  localparam int TAIL_CYCLES = 8;
  localparam int TIMEOUT_NS  = 2_000_000;

  typedef struct packed {
    logic                      hit;
    logic [lkv_pkg::VAL_W-1:0] value;
  } result_t;

  // one request, plus a typed-in result where it is obvious
  typedef struct packed {
    logic [lkv_pkg::ACT_W-1:0] act;
    logic [lkv_pkg::KEY_W-1:0] key;
    logic [lkv_pkg::VAL_W-1:0] val;
    logic                      typed;
    logic                      hit;
    logic [lkv_pkg::VAL_W-1:0] vout;
  } req_row_t;

  // dut inputs, all known from time zero
  logic                       clk_i                 = 1'b0;
  logic                       rst_ni                = 1'b0;
  logic                       cfg_valid_i           = 1'b0;
  logic [lkv_pkg::CAP_W-1:0]  cfg_capacity_in_use_i = '0;
  logic                       in_valid_i            = 1'b0;
  logic [lkv_pkg::ACT_W-1:0]  in_action_i           = '0;
  logic [lkv_pkg::KEY_W-1:0]  in_key_i              = '0;
  logic [lkv_pkg::VAL_W-1:0]  in_new_value_i        = '0;
  logic                       out_ready_i           = 1'b0;

  // dut outputs
  logic                       cfg_ready_o;
  logic                       in_ready_o;
  logic                       out_valid_o;
  logic                       out_hit_o;
  logic [lkv_pkg::VAL_W-1:0]  out_value_out_o;

  // predictor state: slot 0 is the most recent entry
  logic [lkv_pkg::KEY_W-1:0]  cache_key [ENTRIES];
  logic [lkv_pkg::VAL_W-1:0]  cache_val [ENTRIES];
  int                         held;
  logic [lkv_pkg::CAP_W-1:0]  cache_cap;

  // results still owed by the cache, oldest first
  result_t                    pending [$];
  req_row_t                   directed_rows [$];
  logic [lkv_pkg::KEY_W-1:0]  key_pool [POOL_SIZE];

  // shared flags between the request side and the result side
  bit                         idle_en  = 1'b1;
  bit                         hold_req = 1'b0;

  int                         mismatches = 0;
  int                         n_sent     = 0;
  int                         n_checked  = 0;
  int                         n_hit      = 0;
  int                         n_cfg      = 0;
  int                         n_holds    = 0;

  lru_key_value_cache #(
    .Entries(ENTRIES)
  ) dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_capacity_in_use_i (cfg_capacity_in_use_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .in_action_i           (in_action_i),
    .in_key_i              (in_key_i),
    .in_new_value_i        (in_new_value_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .out_hit_o             (out_hit_o),
    .out_value_out_o       (out_value_out_o)
  );

  // 4 ns clock
  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // recency order predictor
  // ---------------------------------------------------------------------------

  // move the entry at pos to slot 0, sliding the younger ones down by one
  function automatic void move_to_front(input int pos);
    logic [lkv_pkg::KEY_W-1:0] k;
    logic [lkv_pkg::VAL_W-1:0] v;
    k = cache_key[pos];
    v = cache_val[pos];
    for (int i = pos; i > 0; i--) begin
      cache_key[i] = cache_key[i-1];
      cache_val[i] = cache_val[i-1];
    end
    cache_key[0] = k;
    cache_val[0] = v;
  endfunction

  // the least recent entry sits at the end of the order
  function automatic void drop_oldest();
    if (held > 0) held--;
  endfunction

  function automatic void predict_result(input logic [lkv_pkg::ACT_W-1:0] act,
                                         input logic [lkv_pkg::KEY_W-1:0] k,
                                         input logic [lkv_pkg::VAL_W-1:0] v,
                                         output logic hit,
                                         output logic [lkv_pkg::VAL_W-1:0] vout);
    int pos;
    int lim;
    pos = -1;
    // capacity above the slot count acts as the slot count
    lim = (cache_cap > ENTRIES) ? ENTRIES : int'(cache_cap);
    // keys compare as raw bit patterns, first match wins
    for (int i = 0; i < held; i++) begin
      if (pos < 0 && cache_key[i] == k) pos = i;
    end
    hit  = 1'b0;
    vout = '0;
    case (act)
      lkv_pkg::ACT_LOOKUP: begin
        if (pos >= 0) begin
          hit  = 1'b1;
          vout = cache_val[pos];
          move_to_front(pos);
        end
      end
      lkv_pkg::ACT_INSERT: begin
        // a present key keeps its old value, only its recency changes
        if (pos >= 0) begin
          move_to_front(pos);
        end else begin
          // all slots full: the oldest falls off to make room
          if (held >= ENTRIES) held = ENTRIES - 1;
          for (int i = held; i > 0; i--) begin
            cache_key[i] = cache_key[i-1];
            cache_val[i] = cache_val[i-1];
          end
          cache_key[0] = k;
          cache_val[0] = v;
          held++;
        end
        // at most one eviction per insert, even after the capacity dropped
        if (held > lim) drop_oldest();
      end
      lkv_pkg::ACT_ERASE: begin
        if (pos >= 0) begin
          hit = 1'b1;
          for (int i = pos; i + 1 < held; i++) begin
            cache_key[i] = cache_key[i+1];
            cache_val[i] = cache_val[i+1];
          end
          drop_oldest();
        end
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // request side helpers
  // ---------------------------------------------------------------------------

  task automatic add_row(input logic [lkv_pkg::ACT_W-1:0] act,
                         input logic [lkv_pkg::KEY_W-1:0] key,
                         input logic [lkv_pkg::VAL_W-1:0] val, input logic typed,
                         input logic hit, input logic [lkv_pkg::VAL_W-1:0] vout);
    directed_rows.push_back('{act, key, val, typed, hit, vout});
  endtask

  // present one request and hold it until the cache takes it; entered and
  // left at a falling edge
  task automatic send_item(input req_row_t r);
    logic                      h;
    logic [lkv_pkg::VAL_W-1:0] vo;
    in_valid_i     <= 1'b1;
    in_action_i    <= r.act;
    in_key_i       <= r.key;
    in_new_value_i <= r.val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // request taken at this edge, the predictor moves on with it
    predict_result(r.act, r.key, r.val, h, vo);
    if (r.typed) pending.push_back('{r.hit, r.vout});
    else         pending.push_back('{h, vo});
    n_sent++;
    if (h) n_hit++;
    @(negedge clk_i);
  endtask

  // stop offering requests and wait for every owed result
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // capacity is only written while the cache has nothing in flight
  task automatic write_capacity(input logic [lkv_pkg::CAP_W-1:0] c);
    settle();
    repeat (CFG_GUARD) @(negedge clk_i);
    cfg_valid_i           <= 1'b1;
    cfg_capacity_in_use_i <= c;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cache_cap = c;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly keys from a small pool so hits, refreshes and evictions are
  // frequent; now and then a fully random key
  function automatic req_row_t make_request();
    req_row_t r;
    int       sel;
    r     = '0;
    sel   = $urandom_range(0, 99);
    r.act = (sel < 40) ? lkv_pkg::ACT_LOOKUP :
            (sel < 80) ? lkv_pkg::ACT_INSERT :
            (sel < 95) ? lkv_pkg::ACT_ERASE  : ACT_NOP;
    if ($urandom_range(0, 99) < 85) r.key = key_pool[$urandom_range(0, POOL_SIZE-1)];
    else                            r.key = $urandom();
    r.val = lkv_pkg::VAL_W'($urandom());
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: ready driver with random stalls and the long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_side
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // long stall, counted here, so the cache backs up and stops taking requests
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
        n_holds++;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every taken result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected result hit=%0b value_out=%h", $time, out_hit_o,
                 out_value_out_o);
        mismatches++;
      end else begin
        want = pending.pop_front();
        n_checked++;
        if (out_hit_o !== want.hit) begin
          $display("%0t: hit mismatch, expected %0b actual %0b", $time, want.hit,
                   out_hit_o);
          mismatches++;
        end
        if (out_value_out_o !== want.value) begin
          $display("%0t: value_out mismatch, expected %h actual %h", $time,
                   want.value, out_value_out_o);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    req_row_t r;
    int       caps [NUM_PHASES];

    // predictor after reset: empty, capacity at its reset value
    held      = 0;
    cache_cap = lkv_pkg::CAP_RESET;

    // directed table: key and value extremes, every action, present-key
    // insert, the unused action code, misses on an empty and a partly filled
    // cache, erase of every held entry
    add_row(lkv_pkg::ACT_LOOKUP, 32'h0000_0000, 31'h0000_0000, 1'b1, 1'b0, 31'h0);
    add_row(lkv_pkg::ACT_ERASE,  32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b0, 31'h0);
    add_row(ACT_NOP,             32'h0000_0000, 31'h7FFF_FFFF, 1'b1, 1'b0, 31'h0);
    add_row(lkv_pkg::ACT_INSERT, 32'h8000_0000, 31'h7FFF_FFFF, 1'b1, 1'b0, 31'h0);
    add_row(lkv_pkg::ACT_INSERT, 32'h7FFF_FFFF, 31'h0000_0000, 1'b1, 1'b0, 31'h0);
    add_row(lkv_pkg::ACT_INSERT, 32'hFFFF_FFFF, 31'h2AAA_AAAA, 1'b1, 1'b0, 31'h0);
    add_row(lkv_pkg::ACT_INSERT, 32'h0000_0000, 31'h5555_5555, 1'b1, 1'b0, 31'h0);
    add_row(lkv_pkg::ACT_LOOKUP, 32'h8000_0000, 31'h0000_0000, 1'b0, 1'b0, 31'h0);
    add_row(lkv_pkg::ACT_LOOKUP, 32'h7FFF_FFFF, 31'h1234_5678, 1'b0, 1'b0, 31'h0);
    // insert of a present key keeps the old value
    add_row(lkv_pkg::ACT_INSERT, 32'h8000_0000, 31'h0000_0001, 1'b1, 1'b0, 31'h0);
    add_row(lkv_pkg::ACT_LOOKUP, 32'h8000_0000, 31'h0000_0000, 1'b0, 1'b0, 31'h0);
    add_row(ACT_NOP,             32'h8000_0000, 31'h0000_0000, 1'b1, 1'b0, 31'h0);
    add_row(lkv_pkg::ACT_LOOKUP, 32'h0000_0001, 31'h0000_0000, 1'b1, 1'b0, 31'h0);
    add_row(lkv_pkg::ACT_ERASE,  32'hFFFF_FFFF, 31'h0000_0000, 1'b0, 1'b0, 31'h0);
    add_row(lkv_pkg::ACT_ERASE,  32'hFFFF_FFFF, 31'h0000_0000, 1'b0, 1'b0, 31'h0);
    add_row(lkv_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 31'h0000_0000, 1'b0, 1'b0, 31'h0);
    add_row(lkv_pkg::ACT_LOOKUP, 32'h0000_0000, 31'h0000_0000, 1'b0, 1'b0, 31'h0);
    add_row(lkv_pkg::ACT_ERASE,  32'h8000_0000, 31'h0000_0000, 1'b0, 1'b0, 31'h0);
    add_row(lkv_pkg::ACT_ERASE,  32'h7FFF_FFFF, 31'h0000_0000, 1'b0, 1'b0, 31'h0);
    add_row(lkv_pkg::ACT_ERASE,  32'h0000_0000, 31'h0000_0000, 1'b0, 1'b0, 31'h0);
    add_row(lkv_pkg::ACT_LOOKUP, 32'h0000_0000, 31'h0000_0000, 1'b0, 1'b0, 31'h0);

    // capacity per phase: zero, one, the slot count, above it, and drops
    // below the held count right after full phases
    caps    = '{31, 0, 1, 16, 2, 31, 7, 0, 16, 3, 16};
    caps[6] = $urandom_range(3, 15);

    // reset held low from time zero, released at a falling edge
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at the reset capacity
    foreach (directed_rows[i]) begin
      if (idle_en && $urandom_range(0, 3) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
      send_item(directed_rows[i]);
    end

    // random phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(lkv_pkg::CAP_W'(caps[p]));
      // new key pool per phase, key extremes always in it
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'h8000_0000;
      key_pool[2] = 32'h7FFF_FFFF;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();
      // last phase runs back to back on both sides
      idle_en = (p != NUM_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long result stall while requests keep coming
        if (p == 3 && n == 40) hold_req = 1'b1;
        // request side pause until the cache has answered everything
        if (p == 6 && n == 90) settle();
        if (idle_en && $urandom_range(0, 3) == 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 6)) @(negedge clk_i);
        end
        r = make_request();
        send_item(r);
      end
    end

    // wait out every owed result, then an idle tail to catch strays
    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("summary: %0d requests sent, %0d results checked, %0d hits", n_sent,
             n_checked, n_hit);
    $display("summary: %0d capacity writes, %0d long result stalls, %0d mismatches",
             n_cfg, n_holds, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout at %0t with %0d results owed", $time, pending.size());
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lkv_pkg.sv
rtl/core/lkv_ctrl.sv
rtl/core/lkv_datapath.sv
rtl/core/lru_key_value_cache.sv
rtl/core/lkv_checker.sv
tb/testbench.sv
